### hdl/tsw_pkg.sv
// ----------------------------------------------------------------------------
// tsw_pkg: shared types, codes and helpers of the texture sampler.
// Holds the operation and format codes, the register indexes and the small
// arithmetic helpers that the coordinate fold and the texel decode use.
// ----------------------------------------------------------------------------
package tsw_pkg;

  localparam int TEXEL_BYTES_DEF   = 16384;
  localparam int PALETTE_DEPTH_DEF = 256;
  localparam int MAX_WIDTH         = 64;
  localparam int MAX_HEIGHT        = 64;

  localparam int DIM_W = 7;   // tile_width / tile_height register width
  localparam int MOD_W = 8;   // fold modulus, up to twice a dimension
  localparam int MAG_W = 11;  // scaled coordinate magnitude

  typedef logic [1:0] op_t;
  localparam op_t OP_TEXEL   = 2'd0;
  localparam op_t OP_PALETTE = 2'd1;
  localparam op_t OP_SAMPLE  = 2'd2;

  typedef logic [3:0] fmt_t;
  localparam fmt_t FMT_I4       = 4'd0;
  localparam fmt_t FMT_I8       = 4'd1;
  localparam fmt_t FMT_IA4      = 4'd2;
  localparam fmt_t FMT_IA8      = 4'd3;
  localparam fmt_t FMT_IA16     = 4'd4;
  localparam fmt_t FMT_CI4      = 4'd5;
  localparam fmt_t FMT_CI8      = 4'd6;
  localparam fmt_t FMT_CI4_IA   = 4'd7;
  localparam fmt_t FMT_CI8_IA   = 4'd8;
  localparam fmt_t FMT_RGBA16   = 4'd9;
  localparam fmt_t FMT_RGB15    = 4'd10;
  localparam fmt_t FMT_RGB24    = 4'd11;
  localparam fmt_t FMT_RGBA32   = 4'd12;

  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_FORMAT   = 3'd0;
  localparam cfg_idx_t CFG_WIDTH    = 3'd1;
  localparam cfg_idx_t CFG_HEIGHT   = 3'd2;
  localparam cfg_idx_t CFG_WRAP_S   = 3'd3;
  localparam cfg_idx_t CFG_WRAP_T   = 3'd4;
  localparam cfg_idx_t CFG_PAL_CNT  = 3'd5;
  localparam cfg_idx_t CFG_SCALE_S  = 3'd6;
  localparam cfg_idx_t CFG_SCALE_T  = 3'd7;

  typedef logic [1:0] wrap_t;
  localparam wrap_t WRAP_REPEAT = 2'd0;
  localparam wrap_t WRAP_MIRROR = 2'd1;
  localparam wrap_t WRAP_CLAMP  = 2'd2;

  // Period of the fold: twice the size for mirror, the size otherwise.
  function automatic logic [MOD_W-1:0] fold_period(input logic [DIM_W-1:0] size,
                                                   input wrap_t mode);
    return (mode == WRAP_MIRROR) ? {size, 1'b0} : {1'b0, size};
  endfunction

  // Four steps of a restoring remainder, most significant bit first.
  function automatic logic [MOD_W-1:0] rem_step4(input logic [MOD_W-1:0] r_in,
                                                 input logic [3:0] bits,
                                                 input logic [MOD_W-1:0] m);
    logic [MOD_W:0] r;
    r = {1'b0, r_in};
    for (int k = 3; k >= 0; k--) begin
      r = {r[MOD_W-1:0], bits[k]};
      if (r >= {1'b0, m}) begin
        r = r - {1'b0, m};
      end
    end
    return r[MOD_W-1:0];
  endfunction

  // Turns the magnitude remainder into the folded coordinate.
  function automatic logic [DIM_W-1:0] fold_finish(input logic [MOD_W-1:0] r,
                                                   input logic [MAG_W-1:0] p,
                                                   input logic neg,
                                                   input logic [DIM_W-1:0] size,
                                                   input wrap_t mode);
    logic [MOD_W-1:0] m;
    logic [MOD_W-1:0] v;
    logic [MOD_W-1:0] refl;
    logic [DIM_W-1:0] res;
    m    = fold_period(size, mode);
    v    = (neg && (r != '0)) ? (m - r) : r;
    refl = m - {{(MOD_W-1){1'b0}}, 1'b1} - v;
    if (mode == WRAP_CLAMP) begin
      if (neg) begin
        res = '0;
      end else if (p >= {{(MAG_W-DIM_W){1'b0}}, size}) begin
        res = size - {{(DIM_W-1){1'b0}}, 1'b1};
      end else begin
        res = p[DIM_W-1:0];
      end
    end else if ((mode == WRAP_MIRROR) && (v >= {1'b0, size})) begin
      res = refl[DIM_W-1:0];
    end else begin
      res = v[DIM_W-1:0];
    end
    return res;
  endfunction

  function automatic logic [7:0] five_to_eight(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  // 3-bit intensity scaled to 0..255, rounded down.
  function automatic logic [7:0] ia4_level(input logic [2:0] v);
    logic [7:0] res;
    case (v)
      3'd0:    res = 8'd0;
      3'd1:    res = 8'd36;
      3'd2:    res = 8'd72;
      3'd3:    res = 8'd109;
      3'd4:    res = 8'd145;
      3'd5:    res = 8'd182;
      3'd6:    res = 8'd218;
      default: res = 8'd255;
    endcase
    return res;
  endfunction

endpackage

### hdl/tsw_if.sv
// ----------------------------------------------------------------------------
// tsw_in_if / tsw_out_if: request and result channels of the sampler.
// Valid/ready channels; a beat moves at a clock edge with both high.
// ----------------------------------------------------------------------------
interface tsw_in_if;
  import tsw_pkg::*;
  logic               valid;
  logic               ready;
  op_t                op;
  logic [13:0]        address;
  logic [15:0]        write_data;
  logic signed [15:0] coord_s;
  logic signed [15:0] coord_t;

  modport source(output valid, op, address, write_data, coord_s, coord_t,
                 input ready);
  modport sink(input valid, op, address, write_data, coord_s, coord_t,
               output ready);
endinterface

interface tsw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       sample_valid;

  modport source(output valid, red, green, blue, alpha, sample_valid,
                 input ready);
  modport sink(input valid, red, green, blue, alpha, sample_valid,
               output ready);
endinterface

### hdl/tsw_ram.sv
// ----------------------------------------------------------------------------
// tsw_ram: generic single-write, single-read RAM.
// The read data is registered and holds while the read enable is low.
// ----------------------------------------------------------------------------
module tsw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

### hdl/texture_sampler_wrap_decode.sv
// ----------------------------------------------------------------------------
// texture_sampler_wrap_decode: point-sampled texture unit with one tile store.
// A request beat passes through stages 1 to 8 and then the output register.
// Throughput: one request beat per cycle; the nine stages advance together and
// stall as a whole only while the output register holds an untaken beat.
// Reset (rst_n low, synchronous) empties the pipeline and loads the register
// reset values; texel and palette memories are not cleared.
// ----------------------------------------------------------------------------
module texture_sampler_wrap_decode #(
  parameter int TEXEL_BYTES   = tsw_pkg::TEXEL_BYTES_DEF,
  parameter int PALETTE_DEPTH = tsw_pkg::PALETTE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  tsw_pkg::cfg_idx_t  cfg_index,
  input  logic [16:0]        cfg_wdata,
  tsw_in_if.sink             in_bus,
  tsw_out_if.source          out_bus
);
  import tsw_pkg::*;

  // Texel bytes live in four banks split on the two low address bits, so that
  // any four consecutive bytes (the widest texel) can be read from the banks together.
  localparam int AW  = $clog2(TEXEL_BYTES);
  localparam int RW  = AW - 2;
  localparam int BANK_DEPTH = TEXEL_BYTES / 4;
  localparam int PW  = $clog2(PALETTE_DEPTH);

  // --------------------------------------------------------------------------
  // Configuration registers. The user must change them only while the pipeline
  // is empty (the block does not enforce this), as every stage reads them directly.
  // --------------------------------------------------------------------------
  fmt_t             fmt_r;
  logic [DIM_W-1:0] tile_w_r;
  logic [DIM_W-1:0] tile_h_r;
  wrap_t            wrap_s_r;
  wrap_t            wrap_t_r;
  logic [8:0]       pal_cnt_r;
  logic [16:0]      scale_s_r;
  logic [16:0]      scale_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r     <= FMT_I8;
      tile_w_r  <= 7'd1;
      tile_h_r  <= 7'd1;
      wrap_s_r  <= WRAP_REPEAT;
      wrap_t_r  <= WRAP_REPEAT;
      pal_cnt_r <= 9'd0;
      scale_s_r <= 17'h10000;
      scale_t_r <= 17'h10000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FORMAT:  fmt_r     <= cfg_wdata[3:0];
        CFG_WIDTH:   tile_w_r  <= cfg_wdata[6:0];
        CFG_HEIGHT:  tile_h_r  <= cfg_wdata[6:0];
        CFG_WRAP_S:  wrap_s_r  <= cfg_wdata[1:0];
        CFG_WRAP_T:  wrap_t_r  <= cfg_wdata[1:0];
        CFG_PAL_CNT: pal_cnt_r <= cfg_wdata[8:0];
        CFG_SCALE_S: scale_s_r <= cfg_wdata;
        CFG_SCALE_T: scale_t_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control. Every stage moves when the output register is free or
  // its beat is being taken, so a stall holds every stage in place.
  // --------------------------------------------------------------------------
  logic [8:1] v_r;
  logic       out_valid_r;
  logic       adv;

  assign adv          = !out_valid_r || out_bus.ready;
  assign in_bus.ready = adv;

  op_t         op_r   [1:8];
  logic [13:0] addr_r [1:7];
  logic [15:0] data_r [1:7];
  logic        fit_r  [1:8];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v_r         <= {v_r[7:1], in_bus.valid};
      out_valid_r <= v_r[8] && (op_r[8] == OP_SAMPLE);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: coordinate scaling and the tile fit check.
  // A coordinate is split into sign and magnitude so that the shift truncates
  // toward zero; the magnitude times the scale is below 2^32, so eleven bits
  // remain after dropping the 21 fraction bits.
  // --------------------------------------------------------------------------
  logic        neg_s, neg_t;
  logic [16:0] mag_s, mag_t;
  logic [16:0] sc_s, sc_t;
  logic [33:0] prod_s, prod_t;
  logic [13:0] texels;
  logic [16:0] bytes_needed;
  logic        fit_c;

  assign neg_s  = in_bus.coord_s[15];
  assign neg_t  = in_bus.coord_t[15];
  assign mag_s  = neg_s ? (17'h10000 - {1'b0, in_bus.coord_s}) : {1'b0, in_bus.coord_s};
  assign mag_t  = neg_t ? (17'h10000 - {1'b0, in_bus.coord_t}) : {1'b0, in_bus.coord_t};
  assign sc_s   = (scale_s_r == '0) ? 17'h10000 : scale_s_r;
  assign sc_t   = (scale_t_r == '0) ? 17'h10000 : scale_t_r;
  assign prod_s = {17'b0, mag_s} * {17'b0, sc_s};
  assign prod_t = {17'b0, mag_t} * {17'b0, sc_t};
  assign texels = {7'b0, tile_w_r} * {7'b0, tile_h_r};

  always_comb begin
    case (fmt_r)
      FMT_I4, FMT_IA4, FMT_CI4, FMT_CI4_IA:
        bytes_needed = ({3'b0, texels} + 17'd1) >> 1;
      FMT_I8, FMT_IA8, FMT_CI8, FMT_CI8_IA:
        bytes_needed = {3'b0, texels};
      FMT_IA16, FMT_RGBA16, FMT_RGB15:
        bytes_needed = {2'b0, texels, 1'b0};
      FMT_RGB24:
        bytes_needed = {2'b0, texels, 1'b0} + {3'b0, texels};
      FMT_RGBA32:
        bytes_needed = {1'b0, texels, 2'b0};
      default:
        bytes_needed = '1;
    endcase
  end

  assign fit_c = (tile_w_r != '0) && ({2'b0, tile_w_r} <= 9'(MAX_WIDTH)) &&
                 (tile_h_r != '0) && ({2'b0, tile_h_r} <= 9'(MAX_HEIGHT)) &&
                 (fmt_r <= FMT_RGBA32) && (bytes_needed <= 17'(TEXEL_BYTES));

  // Per-axis fold state for stages 1 to 4.
  logic             ns_r [1:4];
  logic             nt_r [1:4];
  logic [MAG_W-1:0] ps_r [1:4];
  logic [MAG_W-1:0] pt_r [1:4];
  logic [MOD_W-1:0] rs_r [2:4];
  logic [MOD_W-1:0] rt_r [2:4];
  logic [MOD_W-1:0] mod_s, mod_t;

  assign mod_s = fold_period(tile_w_r, wrap_s_r);
  assign mod_t = fold_period(tile_h_r, wrap_t_r);

  // Stage 5 and 6 results.
  logic [DIM_W-1:0] x5_r, y5_r;
  logic [13:0]      idx6_r;
  logic [13:0]      row_base;

  assign row_base = {7'b0, y5_r} * {7'b0, tile_w_r};

  always_ff @(posedge clk) begin
    if (adv) begin
      op_r[1]   <= in_bus.op;
      addr_r[1] <= in_bus.address;
      data_r[1] <= in_bus.write_data;
      fit_r[1]  <= fit_c;
      for (int k = 2; k <= 8; k++) begin
        op_r[k]  <= op_r[k-1];
        fit_r[k] <= fit_r[k-1];
      end
      for (int k = 2; k <= 7; k++) begin
        addr_r[k] <= addr_r[k-1];
        data_r[k] <= data_r[k-1];
      end

      // Stage 1 registers the scaled magnitudes.
      ns_r[1] <= neg_s;
      nt_r[1] <= neg_t;
      ps_r[1] <= prod_s[31:21];
      pt_r[1] <= prod_t[31:21];
      for (int k = 2; k <= 4; k++) begin
        ns_r[k] <= ns_r[k-1];
        nt_r[k] <= nt_r[k-1];
        ps_r[k] <= ps_r[k-1];
        pt_r[k] <= pt_r[k-1];
      end

      // Stages 2 to 4: the remainder is built four magnitude bits at a time.
      rs_r[2] <= rem_step4('0, {1'b0, ps_r[1][10:8]}, mod_s);
      rt_r[2] <= rem_step4('0, {1'b0, pt_r[1][10:8]}, mod_t);
      rs_r[3] <= rem_step4(rs_r[2], ps_r[2][7:4], mod_s);
      rt_r[3] <= rem_step4(rt_r[2], pt_r[2][7:4], mod_t);
      rs_r[4] <= rem_step4(rs_r[3], ps_r[3][3:0], mod_s);
      rt_r[4] <= rem_step4(rt_r[3], pt_r[3][3:0], mod_t);

      // Stage 5: sign correction, mirror reflection or clamp.
      x5_r <= fold_finish(rs_r[4], ps_r[4], ns_r[4], tile_w_r, wrap_s_r);
      y5_r <= fold_finish(rt_r[4], pt_r[4], nt_r[4], tile_h_r, wrap_t_r);

      // Stage 6: texel index in row-major order.
      idx6_r <= row_base + {7'b0, x5_r};
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: byte address of the texel and the bank reads. Texel writes are
  // done at this same stage, so a sample sees every write that came before it.
  // --------------------------------------------------------------------------
  logic [16:0] byte_addr;
  logic [16:0] wr_addr_ext;
  logic        tex_wr;
  logic [7:0]  bank_q [4];
  logic [1:0]  alo7_r;
  logic        nib7_r;

  always_comb begin
    case (fmt_r)
      FMT_I4, FMT_IA4, FMT_CI4, FMT_CI4_IA:
        byte_addr = {3'b0, idx6_r} >> 1;
      FMT_IA16, FMT_RGBA16, FMT_RGB15:
        byte_addr = {2'b0, idx6_r, 1'b0};
      FMT_RGB24:
        byte_addr = {2'b0, idx6_r, 1'b0} + {3'b0, idx6_r};
      FMT_RGBA32:
        byte_addr = {1'b0, idx6_r, 2'b0};
      default:
        byte_addr = {3'b0, idx6_r};
    endcase
  end

  assign wr_addr_ext = {3'b0, addr_r[6]};
  assign tex_wr      = adv && v_r[6] && (op_r[6] == OP_TEXEL) &&
                       (wr_addr_ext < 17'(TEXEL_BYTES));

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [1:0]  off;
    logic [16:0] rd_addr;

    // Each bank fetches the one byte of the four-byte window that it holds.
    assign off     = 2'(b) - byte_addr[1:0];
    assign rd_addr = byte_addr + {15'b0, off};

    tsw_ram #(
      .WIDTH (8),
      .DEPTH (BANK_DEPTH)
    ) u_bank (
      .clk     (clk),
      .we      (tex_wr && (addr_r[6][1:0] == 2'(b))),
      .waddr   (wr_addr_ext[AW-1:2]),
      .wdata   (data_r[6][7:0]),
      .re      (adv),
      .raddr   (rd_addr[AW-1:2]),
      .rdata_r (bank_q[b])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      alo7_r <= byte_addr[1:0];
      nib7_r <= idx6_r[0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 8: bytes back in address order, the nibble pick and the palette
  // lookup. Palette writes share this stage for the same ordering reason.
  // --------------------------------------------------------------------------
  logic [7:0]  byte7 [4];
  logic [3:0]  nib7;
  logic [7:0]  pal_idx;
  logic [8:0]  pal_lim;
  logic        pal_wr;
  logic [15:0] pal_q;
  logic [7:0]  byte8_r [4];
  logic [3:0]  nib8_r;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      byte7[k] = bank_q[2'(alo7_r + 2'(k))];
    end
  end

  // An even texel index takes the high nibble.
  assign nib7    = nib7_r ? byte7[0][3:0] : byte7[0][7:4];
  assign pal_lim = (pal_cnt_r < 9'(PALETTE_DEPTH)) ? pal_cnt_r : 9'(PALETTE_DEPTH);

  always_comb begin
    if ((fmt_r == FMT_CI4) || (fmt_r == FMT_CI4_IA)) begin
      pal_idx = {4'b0, nib7};
    end else begin
      pal_idx = byte7[0];
    end
    // An index beyond the loaded palette falls back to entry zero.
    if ({1'b0, pal_idx} >= pal_lim) begin
      pal_idx = '0;
    end
  end

  assign pal_wr = adv && v_r[7] && (op_r[7] == OP_PALETTE) &&
                  ({2'b0, addr_r[7]} < 16'(PALETTE_DEPTH));

  tsw_ram #(
    .WIDTH (16),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk     (clk),
    .we      (pal_wr),
    .waddr   (addr_r[7][PW-1:0]),
    .wdata   (data_r[7]),
    .re      (adv),
    .raddr   (pal_idx[PW-1:0]),
    .rdata_r (pal_q)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      byte8_r <= byte7;
      nib8_r  <= nib7;
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: format decode to 8-bit RGBA into the output register.
  // An unfit tile yields a zero color with sample_valid low.
  // --------------------------------------------------------------------------
  logic [7:0]  red_c, green_c, blue_c, alpha_c;
  logic [15:0] word16;
  logic [7:0]  red_r, green_r, blue_r, alpha_r;
  logic        svalid_r;

  always_comb begin
    word16  = {byte8_r[0], byte8_r[1]};
    red_c   = '0;
    green_c = '0;
    blue_c  = '0;
    alpha_c = 8'hff;
    case (fmt_r)
      FMT_I4: begin
        red_c = {nib8_r, nib8_r};
      end
      FMT_IA4: begin
        red_c   = ia4_level(nib8_r[3:1]);
        alpha_c = nib8_r[0] ? 8'hff : 8'h00;
      end
      FMT_IA8: begin
        red_c   = {byte8_r[0][7:4], byte8_r[0][7:4]};
        alpha_c = {byte8_r[0][3:0], byte8_r[0][3:0]};
      end
      FMT_IA16: begin
        red_c   = byte8_r[0];
        alpha_c = byte8_r[1];
      end
      FMT_CI4, FMT_CI8: begin
        word16 = pal_q;
      end
      FMT_CI4_IA, FMT_CI8_IA: begin
        red_c   = pal_q[15:8];
        alpha_c = pal_q[7:0];
      end
      FMT_RGB24: begin
        red_c   = byte8_r[0];
        green_c = byte8_r[1];
        blue_c  = byte8_r[2];
      end
      FMT_RGBA32: begin
        red_c   = byte8_r[0];
        green_c = byte8_r[1];
        blue_c  = byte8_r[2];
        alpha_c = byte8_r[3];
      end
      default: begin
        red_c = byte8_r[0];
      end
    endcase

    // Intensity formats replicate one value over the three color channels.
    if ((fmt_r == FMT_I4) || (fmt_r == FMT_I8) || (fmt_r == FMT_IA4) ||
        (fmt_r == FMT_IA8) || (fmt_r == FMT_IA16) || (fmt_r == FMT_CI4_IA) ||
        (fmt_r == FMT_CI8_IA)) begin
      green_c = red_c;
      blue_c  = red_c;
    end

    // RGBA5551 words, either straight from the texels or from the palette.
    if ((fmt_r == FMT_CI4) || (fmt_r == FMT_CI8) || (fmt_r == FMT_RGBA16) ||
        (fmt_r == FMT_RGB15)) begin
      red_c   = five_to_eight(word16[15:11]);
      green_c = five_to_eight(word16[10:6]);
      blue_c  = five_to_eight(word16[5:1]);
      alpha_c = (word16[0] || (fmt_r == FMT_RGB15)) ? 8'hff : 8'h00;
    end

    if (!fit_r[8]) begin
      red_c   = '0;
      green_c = '0;
      blue_c  = '0;
      alpha_c = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      red_r    <= red_c;
      green_r  <= green_c;
      blue_r   <= blue_c;
      alpha_r  <= alpha_c;
      svalid_r <= fit_r[8];
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.red          = red_r;
  assign out_bus.green        = green_r;
  assign out_bus.blue         = blue_r;
  assign out_bus.alpha        = alpha_r;
  assign out_bus.sample_valid = svalid_r;

`ifndef SYNTHESIS
  // A rejected sample always carries a black, transparent color.
  a_unfit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !svalid_r) |->
      (red_r == '0) && (green_r == '0) && (blue_r == '0) && (alpha_r == '0))
    else $error("unfit sample with nonzero color");

  // The folded coordinates stay inside the tile.
  a_x_in_tile: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[5] && fit_r[5]) |-> (x5_r < tile_w_r))
    else $error("horizontal coordinate outside the tile");

  a_y_in_tile: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[5] && fit_r[5]) |-> (y5_r < tile_h_r))
    else $error("vertical coordinate outside the tile");

  // A sample leaving the last stage becomes an output beat.
  a_sample_out: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && v_r[8] && (op_r[8] == OP_SAMPLE)) |=> out_valid_r)
    else $error("sample lost at the output register");
`endif

endmodule
